/* rtl/lspv_pkg.sv */
// Shared types, constants and widths for the looping sample playback voice.
`default_nettype none

package lspv_pkg;

	// Store and phase geometry
	localparam int SAMPLE_DEPTH = 32768;
	localparam int FRAC_BITS    = 16;
	localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
	localparam int LEN_W        = ADDR_W + 1;

	// Field widths
	localparam int SAMPLE_W  = 16;
	localparam int BASE_W    = 24;
	localparam int BEND_W    = 15;
	localparam int BEND_FRAC = 14;
	localparam int STEP_W    = BASE_W + BEND_W - BEND_FRAC;
	localparam int GAIN_W    = 32;
	localparam int PAN_W     = 7;

	// Phase accumulator holds position, overshoot and one step of headroom
	localparam int PHASE_BASE_W = (ADDR_W + FRAC_BITS > STEP_W) ? ADDR_W + FRAC_BITS : STEP_W;
	localparam int PHASE_W      = PHASE_BASE_W + 2;
	localparam int OVI_W        = PHASE_W - FRAC_BITS;

	// Decoupling queue
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SAMPLE_LENGTH,
		REG_LOOP_LENGTH,
		REG_LOOP_MODE,
		REG_BASE_STEP,
		REG_FIXED_PITCH,
		REG_VOLUME_GAIN,
		REG_PAN_POSITION
	} cfg_reg_t;

	// Operation codes of an input transaction
	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_LOAD    = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	// Loop modes; every other code stops at the end
	localparam logic [1:0] MODE_FWD_LOOP  = 2'd0;
	localparam logic [1:0] MODE_PING_PONG = 2'd1;

	// Pan law
	localparam logic [PAN_W-1:0] PAN_CENTER = 7'd64;
	localparam logic [PAN_W:0]   PAN_FULL   = 8'd128;
	localparam int               PAN_SH     = 6;

	typedef enum logic [1:0] {
		KIND_TICK,
		KIND_LOAD,
		KIND_RESTART
	} kind_t;

	typedef struct packed {
		logic [1:0]                 op;
		logic [14:0]                load_address;
		logic signed [SAMPLE_W-1:0] load_data;
		logic [BEND_W-1:0]          pitch_bend;
		logic [15:0]                envelope_gain;
		logic                       envelope_finished;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_sample;
		logic signed [SAMPLE_W-1:0] right_sample;
		logic                       voice_done;
	} out_item_t;

	// Classified work passed from front to back
	typedef struct packed {
		kind_t                      kind;
		logic [ADDR_W-1:0]          addr;
		logic signed [SAMPLE_W-1:0] data;
		logic [STEP_W-1:0]          step;
		logic [GAIN_W-1:0]          gain;
		logic                       finished;
	} q_entry_t;

	// Register contents plus values derived from them
	typedef struct packed {
		logic [BASE_W-1:0]  base_step;
		logic               fixed_pitch;
		logic [15:0]        volume_gain;
		logic [1:0]         loop_mode;
		logic [PAN_W-1:0]   pan_position;
		logic [LEN_W-1:0]   len;
		logic [LEN_W-1:0]   span;
		logic [PHASE_W-1:0] lenq;
		logic [PHASE_W-1:0] startq;
		logic [PHASE_W-1:0] topq;
		logic [PHASE_W-1:0] loopq;
	} voice_cfg_t;

endpackage

`default_nettype wire

/* rtl/looping_sample_playback_voice_top.sv */
// Top level of the looping sample playback voice: registers, front, queue, back.
//
// Input channel (in_valid/in_ready/in_data) takes one transaction per item: a tick,
// a waveform store load, or a restart. Each tick yields exactly one result on the
// output channel (out_valid/out_ready/out_data); loads and restarts yield none.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must write it
// only while the voice is idle, as the block does not enforce this. A tick result
// passes the input stage, the queue and the back end; a forward loop wrap whose
// overshoot is at least the loop span adds a pass through the bit-serial remainder.
// The back takes one item at a time: a tick through phase update, store read, gain
// multiply, pan and output (a finished or ending voice skips to output), a load or
// restart in its dispatch alone. The waveform store has one write and one read port.
// A two-entry queue lets the front keep accepting while the back is busy. Reset clears
// position, direction and finished flag and restores register defaults; the store
// contents are undefined until loaded. When out_ready is low the result register
// holds, the back stalls at its output step, the queue fills, and in_ready drops.
`default_nettype none

module looping_sample_playback_voice_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  lspv_pkg::in_item_t               in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output lspv_pkg::out_item_t              out_data,
	input  logic                             cfg_we,
	input  logic [lspv_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lspv_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import lspv_pkg::*;

	logic [15:0]       sample_length_q;
	logic [14:0]       loop_length_q;
	logic [1:0]        loop_mode_q;
	logic [BASE_W-1:0] base_step_q;
	logic              fixed_pitch_q;
	logic [15:0]       volume_gain_q;
	logic [PAN_W-1:0]  pan_position_q;

	logic [LEN_W-1:0] len_c;
	logic [LEN_W-1:0] lp_c;
	logic [LEN_W-1:0] start_c;
	voice_cfg_t       cfg_q;

	logic     push;
	logic     full;
	logic     pop;
	logic     empty;
	q_entry_t push_data;
	q_entry_t head;

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_length_q <= 16'd32768;
			loop_length_q   <= '0;
			loop_mode_q     <= 2'd2;
			base_step_q     <= 24'd65536;
			fixed_pitch_q   <= 1'b0;
			volume_gain_q   <= 16'd32768;
			pan_position_q  <= PAN_CENTER;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAMPLE_LENGTH: sample_length_q <= cfg_data[15:0];
				REG_LOOP_LENGTH:   loop_length_q   <= cfg_data[14:0];
				REG_LOOP_MODE:     loop_mode_q     <= cfg_data[1:0];
				REG_BASE_STEP:     base_step_q     <= cfg_data[BASE_W-1:0];
				REG_FIXED_PITCH:   fixed_pitch_q   <= cfg_data[0];
				REG_VOLUME_GAIN:   volume_gain_q   <= cfg_data[15:0];
				REG_PAN_POSITION:  pan_position_q  <= cfg_data[PAN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Clamped length and loop, loop start
	always_comb begin
		if (sample_length_q == '0) begin
			len_c = LEN_W'(1);
		end else if (32'(sample_length_q) > SAMPLE_DEPTH) begin
			len_c = LEN_W'(SAMPLE_DEPTH);
		end else begin
			len_c = LEN_W'(sample_length_q);
		end
		if (32'(loop_length_q) >= 32'(len_c)) begin
			lp_c = len_c - LEN_W'(1);
		end else begin
			lp_c = LEN_W'(loop_length_q);
		end
		start_c = len_c - lp_c - LEN_W'(1);
	end

	// Derived settings, refreshed every cycle
	always_ff @(posedge clk) begin
		cfg_q.base_step    <= base_step_q;
		cfg_q.fixed_pitch  <= fixed_pitch_q;
		cfg_q.volume_gain  <= volume_gain_q;
		cfg_q.loop_mode    <= loop_mode_q;
		cfg_q.pan_position <= pan_position_q;
		cfg_q.len          <= len_c;
		cfg_q.span         <= lp_c + LEN_W'(1);
		cfg_q.lenq         <= PHASE_W'(len_c) << FRAC_BITS;
		cfg_q.startq       <= PHASE_W'(start_c) << FRAC_BITS;
		cfg_q.topq         <= PHASE_W'(len_c - LEN_W'(1)) << FRAC_BITS;
		cfg_q.loopq        <= PHASE_W'(lp_c) << FRAC_BITS;
	end

	lspv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cfg       (cfg_q),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	lspv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	lspv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.empty     (empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

/* rtl/lspv_rem.sv */
// Bit-serial remainder unit used for the forward loop wrap.
`default_nettype none

module lspv_rem (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [lspv_pkg::OVI_W-1:0] dividend,
	input  logic [lspv_pkg::LEN_W-1:0] divisor,
	output logic                       done,
	output logic [lspv_pkg::LEN_W-1:0] rem
);
	import lspv_pkg::*;

	localparam int CNT_W = $clog2(OVI_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [OVI_W-1:0] dvd_q;
	logic [LEN_W-1:0] div_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W:0]   trial;
	logic [LEN_W-1:0] rem_nx;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial  = {rem_q, dvd_q[OVI_W-1]};
		rem_nx = LEN_W'(trial);
		if (trial >= {1'b0, div_q}) begin
			rem_nx = LEN_W'(trial - {1'b0, div_q});
		end
	end

	// Step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(OVI_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

/* rtl/lspv_queue.sv */
// Short queue between the front and the back of the voice.
`default_nettype none

module lspv_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  lspv_pkg::q_entry_t push_data,
	output logic               full,
	input  logic               pop,
	output lspv_pkg::q_entry_t head,
	output logic               empty
);
	import lspv_pkg::*;

	localparam int CNT_W = QPTR_W + 1;

	q_entry_t          entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + QPTR_W'(1);
	endfunction

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entries_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

/* rtl/lspv_front.sv */
// Front end: accepts transactions, classifies them, scales step and gain.
`default_nettype none

module lspv_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lspv_pkg::in_item_t   in_data,
	input  lspv_pkg::voice_cfg_t cfg,
	input  logic                 full,
	output logic                 push,
	output lspv_pkg::q_entry_t   push_data
);
	import lspv_pkg::*;

	logic                     valid_s1;
	in_item_t                 item_s1;
	logic                     keep;
	logic                     advance;
	kind_t                    kind;
	logic [BASE_W+BEND_W-1:0] bend_prod;
	logic [STEP_W-1:0]        step;
	logic [GAIN_W-1:0]        gain;

	// Classify: unknown ops and loads past the store are dropped here
	always_comb begin
		keep = 1'b1;
		kind = KIND_TICK;
		case (item_s1.op)
			OP_TICK: begin
				kind = KIND_TICK;
			end
			OP_LOAD: begin
				kind = KIND_LOAD;
				keep = (32'(item_s1.load_address) < SAMPLE_DEPTH);
			end
			OP_RESTART: begin
				kind = KIND_RESTART;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	// Pitch-bent step and combined static/envelope gain
	always_comb begin
		bend_prod = {{BEND_W{1'b0}}, cfg.base_step} * {{BASE_W{1'b0}}, item_s1.pitch_bend};
		if (cfg.fixed_pitch) begin
			step = STEP_W'(cfg.base_step);
		end else begin
			step = STEP_W'(bend_prod >> BEND_FRAC);
		end
		gain = GAIN_W'(cfg.volume_gain) * GAIN_W'(item_s1.envelope_gain);
	end

	always_comb begin
		push_data.kind     = kind;
		push_data.addr     = ADDR_W'(item_s1.load_address);
		push_data.data     = item_s1.load_data;
		push_data.step     = step;
		push_data.gain     = gain;
		push_data.finished = item_s1.envelope_finished;
	end

	assign push     = valid_s1 && keep && !full;
	assign advance  = valid_s1 && (!keep || !full);
	assign in_ready = !valid_s1 || advance;

	// Input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

endmodule

`default_nettype wire

/* rtl/lspv_back.sv */
// Back end: phase and loop control, waveform store, gain and pan, result register.
`default_nettype none

module lspv_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lspv_pkg::voice_cfg_t cfg,
	input  logic                 empty,
	input  lspv_pkg::q_entry_t   head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lspv_pkg::out_item_t  out_data
);
	import lspv_pkg::*;

	localparam int PROD_W  = SAMPLE_W + GAIN_W + 1;
	localparam int MONO_SH = 31;
	localparam int MONO_W  = PROD_W - MONO_SH;
	localparam int PANP_W  = MONO_W + PAN_W + 2;
	localparam int SIDE_W  = PANP_W - PAN_SH;

	localparam logic signed [PROD_W-1:0] MONO_HALF = PROD_W'(1) << (MONO_SH - 1);
	localparam logic signed [PANP_W-1:0] PAN_HALF  = PANP_W'(1) << (PAN_SH - 1);
	localparam logic signed [SIDE_W-1:0] SAT_HI    = SIDE_W'(32767);
	localparam logic signed [SIDE_W-1:0] SAT_LO    = -SIDE_W'(32768);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_READ,
		S_MUL,
		S_OUT
	} state_t;

	state_t                     state_q;
	logic [PHASE_W-1:0]         phase_q;
	logic                       fwd_q;
	logic                       term_q;
	logic                       out_valid_q;
	out_item_t                  out_data_q;
	logic                       done_q;
	logic [GAIN_W-1:0]          gain_q;
	logic [FRAC_BITS-1:0]       frac_q;
	logic signed [SAMPLE_W-1:0] rd_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [SAMPLE_W-1:0] wave_mem [SAMPLE_DEPTH];

	logic               is_tick;
	logic               tick_dead;
	logic               wrap;
	logic               wrap_fast;
	logic               one_shot_end;
	logic               need_div;
	logic               rem_start;
	logic               rem_done;
	logic [LEN_W-1:0]   rem_val;
	logic [PHASE_W-1:0] sum;
	logic [PHASE_W-1:0] over;
	logic [OVI_W-1:0]   over_hi;
	logic [PHASE_W-1:0] fwd_phase;
	logic [PHASE_W-1:0] pp_phase;
	logic [PHASE_W-1:0] thr;
	logic               under;
	logic [PHASE_W-1:0] refl;
	logic [PHASE_W-1:0] refl_c;
	logic [PHASE_W-1:0] dec;
	logic [PHASE_W-1:0] div_phase;
	logic [OVI_W-1:0]   idx_full;
	logic [ADDR_W-1:0]  rd_addr;
	logic               out_load;

	logic signed [PROD_W-1:0] prod_rnd;
	logic signed [MONO_W-1:0] mono;
	logic [PAN_W:0]           pan_k;
	logic signed [PANP_W-1:0] pan_prod;
	logic signed [PANP_W-1:0] pan_rnd;
	logic signed [SIDE_W-1:0] pan_val;
	logic signed [SIDE_W-1:0] left_full;
	logic signed [SIDE_W-1:0] right_full;
	out_item_t                out_c;

	function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SIDE_W-1:0] v);
		if (v > SAT_HI) begin
			return SAMPLE_W'(SAT_HI);
		end
		if (v < SAT_LO) begin
			return SAMPLE_W'(SAT_LO);
		end
		return SAMPLE_W'(v);
	endfunction

	// Dispatch one queued transaction per idle cycle
	assign pop     = (state_q == S_IDLE) && !empty;
	assign is_tick = (head.kind == KIND_TICK);

	// Phase advance and boundary handling for the head tick
	always_comb begin
		tick_dead    = head.finished || term_q;
		sum          = phase_q + PHASE_W'(head.step);
		wrap         = fwd_q && (sum >= cfg.lenq);
		over         = sum - cfg.lenq;
		over_hi      = over[PHASE_W-1:FRAC_BITS];
		wrap_fast    = (PHASE_W'(over_hi) < PHASE_W'(cfg.span));
		fwd_phase    = cfg.startq + over;
		pp_phase     = (over > cfg.loopq) ? cfg.startq : (cfg.topq - over);
		thr          = cfg.startq + PHASE_W'(head.step);
		under        = (phase_q <= thr);
		refl         = thr - phase_q + cfg.startq;
		refl_c       = (refl >= cfg.lenq) ? (cfg.lenq - PHASE_W'(1)) : refl;
		dec          = phase_q - PHASE_W'(head.step);
		one_shot_end = wrap && (cfg.loop_mode != MODE_FWD_LOOP)
			&& (cfg.loop_mode != MODE_PING_PONG);
		need_div     = !tick_dead && wrap && (cfg.loop_mode == MODE_FWD_LOOP) && !wrap_fast;
	end

	assign rem_start = pop && is_tick && need_div;
	assign div_phase = cfg.startq + ((PHASE_W'(rem_val) << FRAC_BITS) | PHASE_W'(frac_q));

	lspv_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (over_hi),
		.divisor  (cfg.span),
		.done     (rem_done),
		.rem      (rem_val)
	);

	// Read index, held below the sample length
	always_comb begin
		idx_full = phase_q[PHASE_W-1:FRAC_BITS];
		if (PHASE_W'(idx_full) >= PHASE_W'(cfg.len)) begin
			rd_addr = ADDR_W'(cfg.len - LEN_W'(1));
		end else begin
			rd_addr = ADDR_W'(idx_full);
		end
	end

	// Mono rounding, pan attenuation and saturation
	always_comb begin
		prod_rnd = prod_q + MONO_HALF;
		mono     = prod_rnd[PROD_W-1:MONO_SH];
		if (cfg.pan_position < PAN_CENTER) begin
			pan_k = {1'b0, cfg.pan_position};
		end else begin
			pan_k = PAN_FULL - {1'b0, cfg.pan_position};
		end
		pan_prod   = PANP_W'(mono) * $signed(PANP_W'(pan_k));
		pan_rnd    = pan_prod + PAN_HALF;
		pan_val    = pan_rnd[PANP_W-1:PAN_SH];
		left_full  = SIDE_W'(mono);
		right_full = SIDE_W'(mono);
		if (cfg.pan_position < PAN_CENTER) begin
			right_full = pan_val;
		end else if (cfg.pan_position > PAN_CENTER) begin
			left_full = pan_val;
		end
		if (done_q) begin
			out_c.left_sample  = '0;
			out_c.right_sample = '0;
			out_c.voice_done   = 1'b1;
		end else begin
			out_c.left_sample  = sat16(left_full);
			out_c.right_sample = sat16(right_full);
			out_c.voice_done   = 1'b0;
		end
	end

	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	// Sequencer, voice state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= '0;
			fwd_q       <= 1'b1;
			term_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!empty) begin
						case (head.kind)
							KIND_RESTART: begin
								phase_q <= '0;
								fwd_q   <= 1'b1;
								term_q  <= 1'b0;
							end
							KIND_TICK: begin
								if (tick_dead) begin
									if (head.finished) begin
										term_q <= 1'b1;
									end
									state_q <= S_OUT;
								end else if (fwd_q) begin
									if (!wrap) begin
										phase_q <= sum;
										state_q <= S_READ;
									end else if (cfg.loop_mode == MODE_FWD_LOOP) begin
										if (wrap_fast) begin
											phase_q <= fwd_phase;
											state_q <= S_READ;
										end else begin
											state_q <= S_DIV;
										end
									end else if (cfg.loop_mode == MODE_PING_PONG) begin
										phase_q <= pp_phase;
										fwd_q   <= 1'b0;
										state_q <= S_READ;
									end else begin
										phase_q <= sum;
										term_q  <= 1'b1;
										state_q <= S_OUT;
									end
								end else begin
									if (under) begin
										phase_q <= refl_c;
										fwd_q   <= 1'b1;
									end else begin
										phase_q <= dec;
									end
									state_q <= S_READ;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_DIV: begin
					if (rem_done) begin
						phase_q <= div_phase;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						out_data_q  <= out_c;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Per-tick working registers
	always_ff @(posedge clk) begin
		if (pop && is_tick) begin
			done_q <= tick_dead || one_shot_end;
			gain_q <= head.gain;
			frac_q <= over[FRAC_BITS-1:0];
		end
		if (state_q == S_MUL) begin
			prod_q <= rd_q * $signed({1'b0, gain_q});
		end
	end

	// Waveform store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (pop && (head.kind == KIND_LOAD)) begin
			wave_mem[head.addr] <= head.data;
		end
		if (state_q == S_READ) begin
			rd_q <= wave_mem[rd_addr];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.voice_done) |->
			(out_data_q.left_sample == '0) && (out_data_q.right_sample == '0))
		else $error("finished voice gave nonzero samples");
	a_rem_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		rem_done |-> (state_q == S_DIV))
		else $error("remainder finished outside wrap state");
	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside output state");
`endif

endmodule

`default_nettype wire
